// ===== rtl/core/loc_pkg.sv =====
`timescale 1ns / 1ps

package loc_pkg;

  // default number of stored labels per set
  localparam int unsigned LABEL_DEPTH_DEF = 256;

  // field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned SPAN_W  = CFG_W + LEN_W;

  // configuration register reset values
  localparam logic [CFG_W-1:0] CHAR_WIDTH_RST = 32'h0001_0000;
  localparam logic [CFG_W-1:0] MIN_Y_GAP_RST  = 32'h0001_0000;

  // configuration register indexes
  localparam logic REG_CHAR_WIDTH = 1'b0;
  localparam logic REG_MIN_Y_GAP  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture a new label and store it if the store has room
    logic rd_issue;  // read the next stored label
    logic out_load;  // move the verdict into the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_end;  // all stored labels have been read
    logic busy;      // compare pipeline still holds reads
  } sts_t;

endpackage

// ===== rtl/core/label_overlap_culler.sv =====
`timescale 1ns / 1ps
// each label is compared against the labels stored before it in its set: the store
//   is swept one entry per cycle, the compare pipeline drains, and the verdict is then
//   registered; a new label is taken only once that verdict is in the result register
// a new label can be taken while the previous result still waits for its transfer
// reset: asynchronous, active low; clears the fill count, handshake state and
//   returns char_width and min_y_gap to 1.0; stored labels are not cleared

module label_overlap_culler #(
  parameter int unsigned LABEL_DEPTH = loc_pkg::LABEL_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [loc_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              set_start_i,
  input  logic signed [loc_pkg::COORD_W-1:0] x_pos_i,
  input  logic signed [loc_pkg::COORD_W-1:0] y_pos_i,
  input  logic [loc_pkg::LEN_W-1:0]         name_length_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              keep_o,
  output logic                              overflow_o
);
  import loc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  loc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // label store and compare pipeline
  loc_dp #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .set_start_i   (set_start_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .name_length_i (name_length_i),
    .keep_o        (keep_o),
    .overflow_o    (overflow_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== rtl/core/loc_ctrl.sv =====
`timescale 1ns / 1ps

module loc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output loc_pkg::cmd_t cmd_o,
  input  loc_pkg::sts_t sts_i
);
  import loc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.rd_issue  = 1'b0;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // a taken label always starts a scan
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN)
    else $error("load did not start a scan");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.out_load)
    else $error("pending result overwritten");

  // reads only issued while scanning
  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |-> state_q == S_SCAN && !sts_i.scan_end)
    else $error("read issued outside scan");
`endif

endmodule

// ===== rtl/core/loc_dp.sv =====
`timescale 1ns / 1ps

module loc_dp #(
  parameter int unsigned LABEL_DEPTH = loc_pkg::LABEL_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [loc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          set_start_i,
  input  logic signed [loc_pkg::COORD_W-1:0] x_pos_i,
  input  logic signed [loc_pkg::COORD_W-1:0] y_pos_i,
  input  logic [loc_pkg::LEN_W-1:0]     name_length_i,
  output logic                          keep_o,
  output logic                          overflow_o,
  input  loc_pkg::cmd_t                 cmd_i,
  output loc_pkg::sts_t                 sts_o
);
  import loc_pkg::*;

  localparam int unsigned CNT_W = $clog2(LABEL_DEPTH + 1);
  localparam int unsigned AW    = $clog2(LABEL_DEPTH);
  localparam int unsigned XW    = SPAN_W + 2;   // span sums, signed
  localparam int unsigned YW    = COORD_W + 2;  // row sums, signed
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LABEL_DEPTH);

  // configuration registers
  logic [CFG_W-1:0] char_width_q, min_y_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_width_q <= CHAR_WIDTH_RST;
      min_y_gap_q  <= MIN_Y_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHAR_WIDTH: char_width_q <= cfg_data_i;
        REG_MIN_Y_GAP:  min_y_gap_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // label store
  logic signed [COORD_W-1:0] mem_x [LABEL_DEPTH];
  logic signed [COORD_W-1:0] mem_y [LABEL_DEPTH];
  logic [LEN_W-1:0]          mem_len [LABEL_DEPTH];

  // set fill and scan control
  logic [CNT_W-1:0] count_q, count_d, base_cnt;
  logic [CNT_W-1:0] lim_q, idx_q;
  logic             ovf_q, clash_q;
  logic             room;

  assign base_cnt = set_start_i ? '0 : count_q;
  assign room     = (base_cnt < DEPTH_C);
  assign count_d  = room ? base_cnt + CNT_W'(1) : base_cnt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem_x[base_cnt[AW-1:0]]   <= x_pos_i;
      mem_y[base_cnt[AW-1:0]]   <= y_pos_i;
      mem_len[base_cnt[AW-1:0]] <= name_length_i;
    end
  end

  // new label capture
  logic signed [COORD_W-1:0] nx_q, ny_q;
  logic [SPAN_W-1:0]         nw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nx_q <= x_pos_i;
      ny_q <= y_pos_i;
      nw_q <= char_width_q * name_length_i;
    end
  end

  // stage 1: registered store read
  logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
  logic [LEN_W-1:0]          rd_len_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_x_q   <= mem_x[idx_q[AW-1:0]];
      rd_y_q   <= mem_y[idx_q[AW-1:0]];
      rd_len_q <= mem_len[idx_q[AW-1:0]];
    end
  end

  // stage 2: width of the stored label
  logic signed [COORD_W-1:0] mu_x_q, mu_y_q;
  logic [SPAN_W-1:0]         mu_w_q;
  logic                      mu_vld_q;

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      mu_x_q <= rd_x_q;
      mu_y_q <= rd_y_q;
      mu_w_q <= char_width_q * rd_len_q;
    end
  end

  // stage 3: overlap test, lower x owns the span
  logic              new_left, new_below;
  logic signed [XW-1:0] lo_x, hi_x, lo_w;
  logic signed [YW-1:0] lo_y, hi_y, gap_e;
  logic              span_hit, row_hit;

  always_comb begin
    new_left  = (nx_q < mu_x_q);
    new_below = (ny_q < mu_y_q);
    lo_x  = new_left ? XW'(nx_q) : XW'(mu_x_q);
    hi_x  = new_left ? XW'(mu_x_q) : XW'(nx_q);
    lo_w  = new_left ? XW'({2'b00, nw_q}) : XW'({2'b00, mu_w_q});
    lo_y  = new_below ? YW'(ny_q) : YW'(mu_y_q);
    hi_y  = new_below ? YW'(mu_y_q) : YW'(ny_q);
    gap_e = YW'({2'b00, min_y_gap_q});
    span_hit = (lo_x + lo_w) > hi_x;
    row_hit  = (lo_y + gap_e) > hi_y;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      lim_q    <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
      clash_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      mu_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      mu_vld_q <= rd_vld_q;
      if (cmd_i.load) begin
        count_q <= count_d;
        lim_q   <= base_cnt;
        idx_q   <= '0;
        ovf_q   <= !room;
        clash_q <= 1'b0;
      end else begin
        if (cmd_i.rd_issue) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (mu_vld_q && span_hit && row_hit) begin
          clash_q <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      keep_o     <= !clash_q;
      overflow_o <= ovf_q;
    end
  end

  assign sts_o.scan_end = (idx_q == lim_q);
  assign sts_o.busy     = rd_vld_q | mu_vld_q;

`ifndef ASSERT_OFF
  // reads stay inside the filled part of the store
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> idx_q < lim_q)
    else $error("read beyond stored labels");

  // fill count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> count_q <= DEPTH_C && count_q != '0)
    else $error("fill count out of range");

  // verdict only taken once the compare pipeline is empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !rd_vld_q && !mu_vld_q && idx_q == lim_q)
    else $error("result taken before scan finished");
`endif

endmodule

// ===== tb/tb_label_overlap_culler.sv =====
`timescale 1ns / 1ps

module tb_label_overlap_culler;

  localparam int unsigned LABEL_DEPTH = loc_pkg::LABEL_DEPTH_DEF;

  // one verdict per label
  typedef struct packed {
    logic keep;
    logic overflow;
  } verdict_t;

  // directed table: a row is either a label or a new register setting
  typedef enum logic {ROW_LABEL, ROW_SETUP} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        start;
    logic [31:0] a;      // x for a label, char width for a setup
    logic [31:0] b;      // y for a label, min y gap for a setup
    logic [7:0]  len;
    bit          typed;  // verdict below is fixed, not predicted
    verdict_t    want;
  } label_row_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic                                cfg_idx_i;
  logic [loc_pkg::CFG_W-1:0]           cfg_data_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                set_start_i;
  logic signed [loc_pkg::COORD_W-1:0]  x_pos_i;
  logic signed [loc_pkg::COORD_W-1:0]  y_pos_i;
  logic [loc_pkg::LEN_W-1:0]           name_length_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic                                keep_o;
  logic                                overflow_o;

  // shadow of the label store and the registers
  logic signed [31:0] label_x_mem   [LABEL_DEPTH];
  logic signed [31:0] label_y_mem   [LABEL_DEPTH];
  logic [7:0]         label_len_mem [LABEL_DEPTH];
  int unsigned        label_fill;
  logic [31:0]        char_width_q;
  logic [31:0]        y_gap_q;

  verdict_t   pending_verdicts_q[$];
  label_row_t directed_rows[$];

  int unsigned mismatches;
  int unsigned n_labels;
  int unsigned n_dropped;
  int unsigned n_overflow;
  int unsigned n_settings;
  bit          feed_calm;
  bit          drain_calm;

  label_overlap_culler #(
    .LABEL_DEPTH(LABEL_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .set_start_i  (set_start_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .name_length_i(name_length_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .keep_o       (keep_o),
    .overflow_o   (overflow_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // greedy culling of one label against every earlier label of the set
  function automatic verdict_t cull_label(input logic start, input logic signed [31:0] x,
                                          input logic signed [31:0] y, input logic [7:0] len);
    verdict_t v;
    longint   cw, gap, nx, ny, nw, ox, oy, ow;
    bit       span_hit, row_hit;
    v.keep     = 1'b1;
    v.overflow = 1'b0;
    cw  = {32'd0, char_width_q};
    gap = {32'd0, y_gap_q};
    nx  = x;
    ny  = y;
    nw  = cw * longint'({56'd0, len});
    if (start) label_fill = 0;
    for (int j = 0; j < label_fill && v.keep; j++) begin
      ox = label_x_mem[j];
      oy = label_y_mem[j];
      ow = cw * longint'({56'd0, label_len_mem[j]});
      // lower x owns the span
      if (nx < ox) span_hit = (nx + nw > ox);
      else span_hit = (ox + ow > nx);
      // lower y plus the gap must stay clear of the higher one
      if (ny < oy) row_hit = (ny + gap > oy);
      else row_hit = (oy + gap > ny);
      if (span_hit && row_hit) v.keep = 1'b0;
    end
    if (label_fill < LABEL_DEPTH) begin
      label_x_mem[label_fill]   = x;
      label_y_mem[label_fill]   = y;
      label_len_mem[label_fill] = len;
      label_fill++;
    end else begin
      v.overflow = 1'b1;
    end
    return v;
  endfunction

  // one label transfer, entered and left at a falling edge
  task automatic push_label(input logic start, input logic [31:0] x, input logic [31:0] y,
                            input logic [7:0] len, input bit typed, input verdict_t want);
    int unsigned idle;
    verdict_t    v;
    if ($urandom_range(0, 29) == 0) feed_calm = !feed_calm;
    idle = feed_calm ? 0 : $urandom_range(0, 18);
    if (idle != 0) begin
      in_valid_i = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    set_start_i   = start;
    x_pos_i       = x;
    y_pos_i       = y;
    name_length_i = len;
    do @(posedge clk_i); while (!in_ready_o);
    v = cull_label(start, x, y, len);
    if (typed) v = want;
    pending_verdicts_q.push_back(v);
    n_labels++;
    if (!v.keep) n_dropped++;
    if (v.overflow) n_overflow++;
    @(negedge clk_i);
  endtask

  // register writes only once every verdict is back
  task automatic load_spacing(input logic [31:0] cw, input logic [31:0] gap);
    in_valid_i = 1'b0;
    while (pending_verdicts_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = loc_pkg::REG_CHAR_WIDTH;
    cfg_data_i = cw;
    @(negedge clk_i);
    cfg_idx_i  = loc_pkg::REG_MIN_Y_GAP;
    cfg_data_i = gap;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    char_width_q = cw;
    y_gap_q      = gap;
    n_settings++;
  endtask

  task automatic add_row(input row_kind_e kind, input logic start, input logic [31:0] a,
                         input logic [31:0] b, input logic [7:0] len, input bit typed,
                         input logic keep, input logic ovf);
    label_row_t r;
    r.kind          = kind;
    r.start         = start;
    r.a             = a;
    r.b             = b;
    r.len           = len;
    r.typed         = typed;
    r.want.keep     = keep;
    r.want.overflow = ovf;
    directed_rows.push_back(r);
  endtask

  // mostly a cluster around the origin, sometimes noise or the rails
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [7:0] rand_len();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 8));
    endcase
  endfunction

  // result side: random stalls, check each transfer
  initial begin
    verdict_t    want;
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) drain_calm = !drain_calm;
      stall = drain_calm ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_verdicts_q.size() == 0) begin
        report_mismatch($sformatf("result with no label pending: keep=%b overflow=%b",
                                  keep_o, overflow_o));
      end else begin
        want = pending_verdicts_q.pop_front();
        if (keep_o !== want.keep)
          report_mismatch($sformatf("keep %b, predicted %b", keep_o, want.keep));
        if (overflow_o !== want.overflow)
          report_mismatch($sformatf("overflow %b, predicted %b", overflow_o, want.overflow));
      end
      @(negedge clk_i);
    end
  end

  // stimulus
  initial begin
    verdict_t    none;
    logic [31:0] cw, gap;
    int unsigned phase_items, set_size;
    none          = '0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = loc_pkg::REG_CHAR_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    set_start_i   = 1'b0;
    x_pos_i       = '0;
    y_pos_i       = '0;
    name_length_i = '0;
    out_ready_i   = 1'b0;
    char_width_q  = loc_pkg::CHAR_WIDTH_RST;
    y_gap_q       = loc_pkg::MIN_Y_GAP_RST;
    label_fill    = 0;
    mismatches    = 0;
    n_labels      = 0;
    n_dropped     = 0;
    n_overflow    = 0;
    n_settings    = 0;
    feed_calm     = 1'b0;
    drain_calm    = 1'b0;

    // reset values: first label after reset has no set start
    add_row(ROW_LABEL, 1'b0, 32'h0000_0000, 32'h0000_0000, 8'd5, 1'b1, 1'b1, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h0001_0000, 32'h0000_0000, 8'd1, 1'b0, 1'b0, 1'b0);
    // span ends exactly at the new anchor
    add_row(ROW_LABEL, 1'b0, 32'h0005_0000, 32'h0000_0000, 8'd1, 1'b0, 1'b0, 1'b0);
    // new label left of the earlier one reaches into it
    add_row(ROW_LABEL, 1'b0, 32'hFFFF_0000, 32'h0000_8000, 8'd2, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 8'hAA, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'd3, 1'b1, 1'b1, 1'b0);
    // zero width and zero gap: equal anchors do not clash
    add_row(ROW_SETUP, 1'b0, 32'h0000_0000, 32'h0000_0000, 8'd0, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b1, 32'h0010_0000, 32'h0010_0000, 8'd10, 1'b1, 1'b1, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h0010_0000, 32'h0010_0000, 8'd10, 1'b1, 1'b1, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h000F_FFFF, 32'h0010_0000, 8'hFF, 1'b0, 1'b0, 1'b0);
    // widest span and gap
    add_row(ROW_SETUP, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'd0, 1'b1, 1'b1, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1, 1'b0, 1'b0, 1'b0);
    // smallest nonzero gap
    add_row(ROW_SETUP, 1'b0, 32'h0001_0000, 32'h0000_0001, 8'd0, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'd4, 1'b1, 1'b1, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h0002_0000, 32'h0000_0000, 8'd4, 1'b0, 1'b0, 1'b0);
    add_row(ROW_LABEL, 1'b0, 32'h0002_0000, 32'h0000_0001, 8'd4, 1'b0, 1'b0, 1'b0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETUP)
        load_spacing(directed_rows[i].a, directed_rows[i].b);
      else
        push_label(directed_rows[i].start, directed_rows[i].a, directed_rows[i].b,
                   directed_rows[i].len, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each with its own spacing
    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          cw  = 32'h0000_0000;
          gap = $urandom_range(32'h0000_8000, 32'h0008_0000);
        end
        2: begin
          cw  = $urandom_range(32'h0000_4000, 32'h0008_0000);
          gap = 32'hFFFF_FFFF;
        end
        4: begin
          cw  = 32'hFFFF_FFFF;
          gap = 32'h0000_0000;
        end
        5: begin
          cw  = $urandom();
          gap = $urandom();
        end
        default: begin
          cw  = $urandom_range(32'h0000_4000, 32'h0008_0000);
          gap = $urandom_range(32'h0000_8000, 32'h0008_0000);
        end
      endcase
      load_spacing(cw, gap);
      phase_items = 0;
      while (phase_items < 55) begin
        // one phase runs a set past capacity
        set_size = (p == 3 && phase_items == 0) ? LABEL_DEPTH + 6 : $urandom_range(1, 40);
        for (int k = 0; k < set_size; k++) begin
          push_label(k == 0 && $urandom_range(0, 9) != 0, rand_coord(), rand_coord(),
                     rand_len(), 1'b0, none);
        end
        phase_items += set_size;
      end
    end

    // drain
    in_valid_i = 1'b0;
    while (pending_verdicts_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("ran %0d labels over %0d spacing settings", n_labels, n_settings);
    $display("%0d kept, %0d dropped, %0d beyond capacity", n_labels - n_dropped, n_dropped,
             n_overflow);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("watchdog expired with %0d results outstanding", pending_verdicts_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
